### hw/rtl/hlfr_pkg.sv
// Package for the hex length frame receiver.
// Holds the phase and event codes, the transaction payload structs and the hex digit decoder.
// No dependencies.
package hlfr_pkg;

  localparam int unsigned BUFFER_DEPTH = 256;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 1'd1;

  localparam logic [7:0] START_CHAR_RESET = 8'h21;
  localparam logic [7:0] END_CHAR_RESET   = 8'h3b;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_DATA    = 3'd3,
    PH_END     = 3'd4,
    PH_PENDING = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_PROGRESS  = 3'd0,
    EV_ACCEPTED  = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_IGNORED   = 3'd3,
    EV_READ      = 3'd4,
    EV_NO_FRAME  = 3'd5
  } event_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       frame_ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [7:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes one ASCII hex digit in either case.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/hex_length_frame_receiver_core.sv
// Hex length frame receiver: each transaction passes the input register, then the result register.
// Throughput one transaction per cycle unless out_ready stalls the result; the input register
// feeds one pass of parse logic into the result register; the payload memory read is prefetched.
// Synchronous active-high reset returns to start-character hunt with control and character registers at defaults.
// The payload memory is not cleared; only entries written by the current frame are read.
// Depends on hlfr_pkg.
module hex_length_frame_receiver_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [hlfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hlfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hlfr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hlfr_pkg::out_item_t               out_data
);
  import hlfr_pkg::*;

  logic [7:0] start_char;
  logic [7:0] end_char;

  in_item_t  in_q;
  logic      hold_q;
  logic      fire;

  phase_t              phase, phase_next;
  logic [7:0]          length_value, length_value_next;
  logic [3:0]          high_digit, high_digit_next;
  logic [ADDR_W-1:0]   byte_count, byte_count_next;
  logic [ADDR_W-1:0]   read_position, read_position_next;

  logic [7:0] payload_store [BUFFER_DEPTH];
  logic [7:0] rd_data;
  logic       mem_we;

  out_item_t  res;
  hex_digit_t digit;
  logic [7:0] count;
  logic [ADDR_W:0] count_inc;
  logic [ADDR_W:0] pos_inc;

  assign fire     = hold_q && (!out_valid || out_ready);
  assign in_ready = !hold_q || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RESET;
      end_char   <= END_CHAR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_CHAR: start_char <= cfg_data;
        CFG_END_CHAR:   end_char   <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_q <= 1'b0;
    end else if (in_ready) begin
      hold_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  assign digit     = hex_decode(in_q.rx_byte);
  assign count     = (in_q.read_limit < length_value) ? in_q.read_limit : length_value;
  assign count_inc = {1'b0, byte_count} + 1'b1;
  assign pos_inc   = {1'b0, read_position} + 1'b1;

  // Next state of the parser for the transaction in the input register.
  always_comb begin
    phase_next         = phase;
    length_value_next  = length_value;
    high_digit_next    = high_digit;
    byte_count_next    = byte_count;
    read_position_next = read_position;
    if (fire) begin
      if (in_q.req_type == REQ_BYTE) begin
        case (phase)
          PH_PENDING: ;
          PH_LEN_HI: begin
            if (digit.ok) begin
              high_digit_next = digit.value;
              phase_next      = PH_LEN_LO;
            end else begin
              phase_next = PH_START;
            end
          end
          PH_LEN_LO: begin
            if (!digit.ok) begin
              phase_next = PH_START;
            end else begin
              length_value_next = {high_digit, digit.value};
              if ({high_digit, digit.value} == 8'd0) begin
                phase_next = PH_START;
              end else begin
                byte_count_next = '0;
                phase_next      = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            byte_count_next = count_inc[ADDR_W-1:0];
            if (count_inc >= {1'b0, length_value}) begin
              phase_next = PH_END;
            end
          end
          PH_END: begin
            if (in_q.rx_byte == end_char) begin
              read_position_next = '0;
              phase_next         = PH_PENDING;
            end else begin
              phase_next = PH_START;
            end
          end
          default: begin
            if (in_q.rx_byte == start_char) begin
              length_value_next = 8'd0;
              phase_next        = PH_LEN_HI;
            end else begin
              phase_next = PH_START;
            end
          end
        endcase
      end else if (phase == PH_PENDING) begin
        if ({1'b0, read_position} < {1'b0, count}) begin
          read_position_next = pos_inc[ADDR_W-1:0];
          if (pos_inc >= {1'b0, count}) begin
            phase_next = PH_START;
          end
        end else begin
          phase_next = PH_START;
        end
      end
    end
  end

  // Result fields for the transaction in the input register.
  always_comb begin
    res.event_res  = EV_PROGRESS;
    res.data_byte  = 8'd0;
    res.byte_valid = 1'b0;
    res.last       = 1'b0;
    if (in_q.req_type == REQ_BYTE) begin
      case (phase)
        PH_PENDING: res.event_res = EV_IGNORED;
        PH_LEN_HI:  res.event_res = digit.ok ? EV_PROGRESS : EV_DROPPED;
        PH_LEN_LO: begin
          if (!digit.ok || {high_digit, digit.value} == 8'd0) begin
            res.event_res = EV_DROPPED;
          end
        end
        PH_DATA:    res.event_res = EV_PROGRESS;
        PH_END:     res.event_res = (in_q.rx_byte == end_char) ? EV_ACCEPTED : EV_DROPPED;
        default:    res.event_res = (in_q.rx_byte == start_char) ? EV_PROGRESS : EV_IGNORED;
      endcase
    end else if (phase != PH_PENDING) begin
      res.event_res = EV_NO_FRAME;
    end else begin
      res.event_res = EV_READ;
      if ({1'b0, read_position} < {1'b0, count}) begin
        res.data_byte  = rd_data;
        res.byte_valid = 1'b1;
        res.last       = (pos_inc >= {1'b0, count});
      end else begin
        res.last = 1'b1;
      end
    end
    res.frame_ready  = (phase_next == PH_PENDING);
    res.frame_length = length_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      length_value  <= 8'd0;
      high_digit    <= 4'd0;
      byte_count    <= '0;
      read_position <= '0;
    end else begin
      phase         <= phase_next;
      length_value  <= length_value_next;
      high_digit    <= high_digit_next;
      byte_count    <= byte_count_next;
      read_position <= read_position_next;
    end
  end

  assign mem_we = fire && (in_q.req_type == REQ_BYTE) && (phase == PH_DATA);

  // The read port always fetches the entry that the next read transaction will use.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_store[byte_count] <= in_q.rx_byte;
    end
    rd_data <= payload_store[read_position_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  a_byte_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid |-> out_data.event_res == EV_READ)
    else $error("payload byte delivered on a non-read result");

  a_last_releases: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> !out_data.frame_ready)
    else $error("frame still pending after its last read");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    hold_q && !fire |=> hold_q && $stable(in_q))
    else $error("input register changed while stalled");

  a_read_within_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PENDING |-> read_position <= length_value)
    else $error("read position beyond frame length");

endmodule
